>>> rtl/sha1_pkg.sv
package sha1_pkg;

  localparam int WORD_W       = 32;
  localparam int HASH_WORDS   = 5;
  localparam int SCHED_WORDS  = 16;
  localparam int ROUNDS       = 80;
  localparam int ROUND_W      = $clog2(ROUNDS + 1);
  localparam int DIGEST_BYTES = 20;
  localparam int DIGEST_W     = $clog2(DIGEST_BYTES);
  localparam int LEN_BYTES    = 8;
  localparam int LEN_IDX_W    = $clog2(LEN_BYTES);

  typedef logic [WORD_W-1:0] word_t;

  // Round constants, one per group of twenty rounds
  localparam word_t K_CH  = 32'h5a827999;
  localparam word_t K_PA1 = 32'h6ed9eba1;
  localparam word_t K_MAJ = 32'h8f1bbcdc;
  localparam word_t K_PA2 = 32'hca62c1d6;

  localparam word_t INIT_HASH [HASH_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Operation codes on the message channel
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Padding: marker byte, and the byte position where the length field starts
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } sha1_in_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       last_byte;
  } sha1_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } sha1_state_t;

  typedef struct packed {
    logic load;
    logic round;
    logic fold;
    logic restore;
  } sha1_core_cmd_t;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

>>> rtl/sha1_stream_if.sv
interface sha1_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/sha1_msg.sv
// Block buffer and message schedule in one sixteen-word shift line.
// Bytes are packed big-endian into words and shifted in; during the rounds
// the line shifts once a round, feeding back the expanded schedule word.
module sha1_msg (
  input  logic                 clk,
  input  logic                 push,
  input  logic [7:0]           push_byte,
  input  logic [1:0]           byte_pos,
  input  logic                 step,
  output sha1_pkg::word_t      w_cur
);

  logic [23:0]     asm_word;
  sha1_pkg::word_t line [sha1_pkg::SCHED_WORDS];
  sha1_pkg::word_t line_in;
  logic            shift;

  // Pick a fresh message word or the next schedule word
  always_comb begin
    shift = step || (push && (byte_pos == 2'd3));
    if (step) begin
      line_in = sha1_pkg::rotl(line[13] ^ line[8] ^ line[2] ^ line[0], 1);
    end else begin
      line_in = {asm_word, push_byte};
    end
  end

  // Collect the first three bytes of a word
  always_ff @(posedge clk) begin
    if (push) begin
      asm_word <= {asm_word[15:0], push_byte};
    end
  end

  // Advance the line: oldest word at the bottom
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < sha1_pkg::SCHED_WORDS - 1; i++) begin
        line[i] <= line[i+1];
      end
      line[sha1_pkg::SCHED_WORDS-1] <= line_in;
    end
  end

  assign w_cur = line[0];

endmodule

>>> rtl/sha1_core.sv
// Chaining words, working variables and the single round unit.
module sha1_core (
  input  logic                     clk,
  input  logic                     rst,
  input  sha1_pkg::sha1_core_cmd_t cmd,
  input  sha1_pkg::word_t          w_cur,
  input  logic [sha1_pkg::DIGEST_W-1:0] byte_sel,
  output logic [7:0]               digest_byte,
  output logic                     round_last
);

  sha1_pkg::word_t hash [sha1_pkg::HASH_WORDS];
  sha1_pkg::word_t a, b, c, d, e;
  logic [sha1_pkg::ROUND_W-1:0] rnd;
  sha1_pkg::word_t f, k, t;
  sha1_pkg::word_t sel_word;

  // Round function and constant by round group
  always_comb begin
    priority if (rnd < sha1_pkg::ROUND_W'(20)) begin
      f = (b & c) | (~b & d);
      k = sha1_pkg::K_CH;
    end else if (rnd < sha1_pkg::ROUND_W'(40)) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K_PA1;
    end else if (rnd < sha1_pkg::ROUND_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1_pkg::K_MAJ;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K_PA2;
    end
    t = sha1_pkg::rotl(a, 5) + f + e + k + w_cur;
  end

  assign round_last = (rnd == sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS - 1));

  // Working variables and round count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a <= hash[0];
      b <= hash[1];
      c <= hash[2];
      d <= hash[3];
      e <= hash[4];
    end else if (cmd.round) begin
      e <= d;
      d <= c;
      c <= sha1_pkg::rotl(b, 30);
      b <= a;
      a <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (cmd.load) begin
      rnd <= '0;
    end else if (cmd.round) begin
      rnd <= rnd + sha1_pkg::ROUND_W'(1);
    end
  end

  // Chaining words: fold in the block result, restore after a digest
  always_ff @(posedge clk) begin
    if (rst || cmd.restore) begin
      for (int i = 0; i < sha1_pkg::HASH_WORDS; i++) begin
        hash[i] <= sha1_pkg::INIT_HASH[i];
      end
    end else if (cmd.fold) begin
      hash[0] <= hash[0] + a;
      hash[1] <= hash[1] + b;
      hash[2] <= hash[2] + c;
      hash[3] <= hash[3] + d;
      hash[4] <= hash[4] + e;
    end
  end

  // Select the digest byte, word 0 first, most significant byte first
  always_comb begin
    unique case (byte_sel[4:2])
      3'd0:    sel_word = hash[0];
      3'd1:    sel_word = hash[1];
      3'd2:    sel_word = hash[2];
      3'd3:    sel_word = hash[3];
      3'd4:    sel_word = hash[4];
      default: sel_word = '0;
    endcase
    unique case (byte_sel[1:0])
      2'd0: digest_byte = sel_word[31:24];
      2'd1: digest_byte = sel_word[23:16];
      2'd2: digest_byte = sel_word[15:8];
      2'd3: digest_byte = sel_word[7:0];
    endcase
  end

endmodule

>>> rtl/sha1_hash_engine.sv
// SHA-1 engine taking one message byte per beat on msg (op 0 absorbs
// data_byte, op 1 ends the message) and returning the 20-byte digest on
// digest, first chaining word first and most significant byte first, with
// last_byte set on the final beat. The byte that completes a 64-byte block
// starts a compression (load, 80 rounds through the single shared round
// adder, fold), during which msg is not ready. A finish inserts 9 to 72
// padding and length bytes, with a step without a push on reaching the
// length field, plus the block compressions they complete, then holds msg
// off until all 20 digest beats have been taken. An empty message is
// allowed and the length counter wraps at 2^64 bits.
module sha1_hash_engine (
  input  logic          clk,
  input  logic          rst,
  sha1_stream_if.sink   msg,
  sha1_stream_if.source digest
);

  sha1_pkg::sha1_state_t    state, state_next;
  sha1_pkg::sha1_state_t    ret_state, ret_state_next;
  sha1_pkg::sha1_core_cmd_t cmd;

  logic [60:0]                     cnt;
  logic [63:0]                     len;
  logic [sha1_pkg::LEN_IDX_W-1:0]  len_idx;
  logic [sha1_pkg::DIGEST_W-1:0]   out_idx;
  logic [5:0]                      pos;
  logic                            push;
  logic [7:0]                      push_byte;
  logic                            step;
  logic                            last_out;
  logic                            round_last;
  logic [7:0]                      core_byte;
  sha1_pkg::word_t                 w_cur;

  assign pos      = cnt[5:0];
  assign last_out = (out_idx == sha1_pkg::DIGEST_W'(sha1_pkg::DIGEST_BYTES - 1));

  // Next state and return point after a compression
  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        if (msg.valid) begin
          if (msg.payload.op == sha1_pkg::OP_FINISH) begin
            state_next = sha1_pkg::ST_PAD_ONE;
          end else if (pos == sha1_pkg::LAST_POS) begin
            state_next     = sha1_pkg::ST_LOAD;
            ret_state_next = sha1_pkg::ST_IDLE;
          end
        end
      end
      sha1_pkg::ST_PAD_ONE: begin
        if (pos == sha1_pkg::LAST_POS) begin
          state_next     = sha1_pkg::ST_LOAD;
          ret_state_next = sha1_pkg::ST_PAD_ZERO;
        end else begin
          state_next = sha1_pkg::ST_PAD_ZERO;
        end
      end
      sha1_pkg::ST_PAD_ZERO: begin
        if (pos == sha1_pkg::LEN_POS) begin
          state_next = sha1_pkg::ST_PAD_LEN;
        end else if (pos == sha1_pkg::LAST_POS) begin
          state_next     = sha1_pkg::ST_LOAD;
          ret_state_next = sha1_pkg::ST_PAD_ZERO;
        end
      end
      sha1_pkg::ST_PAD_LEN: begin
        if (len_idx == sha1_pkg::LEN_IDX_W'(sha1_pkg::LEN_BYTES - 1)) begin
          state_next     = sha1_pkg::ST_LOAD;
          ret_state_next = sha1_pkg::ST_EMIT;
        end
      end
      sha1_pkg::ST_LOAD: state_next = sha1_pkg::ST_ROUND;
      sha1_pkg::ST_ROUND: begin
        if (round_last) begin
          state_next = sha1_pkg::ST_FOLD;
        end
      end
      sha1_pkg::ST_FOLD: state_next = ret_state;
      sha1_pkg::ST_EMIT: begin
        if (digest.ready && last_out) begin
          state_next = sha1_pkg::ST_IDLE;
        end
      end
      default: state_next = sha1_pkg::ST_IDLE;
    endcase
  end

  // Handshakes, byte pushes and core commands
  always_comb begin
    msg.ready    = 1'b0;
    digest.valid = 1'b0;
    push         = 1'b0;
    push_byte    = msg.payload.data_byte;
    step         = 1'b0;
    cmd          = '0;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        msg.ready = 1'b1;
        push      = msg.valid && (msg.payload.op == sha1_pkg::OP_ABSORB);
      end
      sha1_pkg::ST_PAD_ONE: begin
        push      = 1'b1;
        push_byte = sha1_pkg::PAD_MARK;
      end
      sha1_pkg::ST_PAD_ZERO: begin
        push      = (pos != sha1_pkg::LEN_POS);
        push_byte = 8'h00;
      end
      sha1_pkg::ST_PAD_LEN: begin
        push      = 1'b1;
        push_byte = len[63:56];
      end
      sha1_pkg::ST_LOAD:  cmd.load = 1'b1;
      sha1_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        step      = 1'b1;
      end
      sha1_pkg::ST_FOLD:  cmd.fold = 1'b1;
      sha1_pkg::ST_EMIT: begin
        digest.valid = 1'b1;
        cmd.restore  = digest.ready && last_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1_pkg::ST_IDLE;
      ret_state <= sha1_pkg::ST_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  // Byte count: advance per pushed byte, drop after the digest
  always_ff @(posedge clk) begin
    if (rst || cmd.restore) begin
      cnt <= '0;
    end else if (push) begin
      cnt <= cnt + 61'd1;
    end
  end

  // Hold the message length and shift it out most significant byte first
  always_ff @(posedge clk) begin
    if (state == sha1_pkg::ST_IDLE) begin
      len <= {cnt, 3'b000};
    end else if (state == sha1_pkg::ST_PAD_LEN) begin
      len <= {len[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state == sha1_pkg::ST_IDLE) begin
      len_idx <= '0;
    end else if (state == sha1_pkg::ST_PAD_LEN) begin
      len_idx <= len_idx + sha1_pkg::LEN_IDX_W'(1);
    end
  end

  // Digest beat index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_idx <= '0;
    end else if (digest.valid && digest.ready) begin
      out_idx <= last_out ? '0 : out_idx + sha1_pkg::DIGEST_W'(1);
    end
  end

  assign digest.payload = {core_byte, last_out};

  sha1_msg u_msg (
    .clk       (clk),
    .push      (push),
    .push_byte (push_byte),
    .byte_pos  (pos[1:0]),
    .step      (step),
    .w_cur     (w_cur)
  );

  sha1_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .w_cur       (w_cur),
    .byte_sel    (out_idx),
    .digest_byte (core_byte),
    .round_last  (round_last)
  );

  // Input and output sides never open together
  assert property (@(posedge clk) disable iff (rst) msg.ready |-> !digest.valid)
    else $error("msg ready while digest is valid");

  // A byte filling the block starts a compression
  assert property (@(posedge clk) disable iff (rst)
    (msg.valid && msg.ready && msg.payload.op == sha1_pkg::OP_ABSORB &&
     pos == sha1_pkg::LAST_POS) |=> state == sha1_pkg::ST_LOAD)
    else $error("full block did not start a compression");

  // The final length byte lands in the last slot of the block
  assert property (@(posedge clk) disable iff (rst)
    (state == sha1_pkg::ST_PAD_LEN &&
     len_idx == sha1_pkg::LEN_IDX_W'(sha1_pkg::LEN_BYTES - 1)) |-> pos == sha1_pkg::LAST_POS)
    else $error("length field misaligned in padded block");

  // After the last digest beat the count is cleared and input reopens
  assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.payload.last_byte) |=>
    (cnt == '0 && state == sha1_pkg::ST_IDLE))
    else $error("engine not restored after the digest");

endmodule

>>> tb/sha1_digest_check_pkg.sv
package sha1_digest_check_pkg;

  import sha1_pkg::*;

  // Mirror of the engine: chaining words, block buffer and bit count, plus
  // the digest beats still owed by the engine
  class digest_predictor;

    word_t       chain [HASH_WORDS];
    logic [7:0]  blk [64];
    logic [63:0] nbits;
    sha1_out_t   digest_q [$];
    int unsigned mismatches;

    function new();
      chain      = INIT_HASH;
      nbits      = '0;
      mismatches = 0;
      foreach (blk[i]) blk[i] = 8'h00;
    endfunction

    function automatic word_t rol1(word_t v);
      return {v[30:0], v[31]};
    endfunction

    function automatic word_t rol5(word_t v);
      return {v[26:0], v[31:27]};
    endfunction

    function automatic word_t rol30(word_t v);
      return {v[1:0], v[31:2]};
    endfunction

    // Run the 80 rounds over the full buffer and fold into the chain
    function void compress();
      word_t w [ROUNDS];
      word_t a, b, c, d, e, f, k, t;
      for (int i = 0; i < SCHED_WORDS; i++) begin
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (int i = SCHED_WORDS; i < ROUNDS; i++) begin
        w[i] = rol1(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16]);
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < ROUNDS; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = K_CH;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = K_PA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_MAJ;
        end else begin
          f = b ^ c ^ d;
          k = K_PA2;
        end
        t = rol5(a) + f + e + k + w[i];
        e = d;
        d = c;
        c = rol30(b);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // Store one byte at the position the bit count points to
    function void take_byte(logic [7:0] v);
      logic [5:0] pos;
      pos       = nbits[8:3];
      blk[pos]  = v;
      nbits    += 64'd8;
      if (pos == LAST_POS) compress();
    endfunction

    // Note one accepted message beat; a finish queues the 20 digest beats
    function void accept_msg_beat(sha1_in_t beat);
      logic [63:0] len;
      sha1_out_t   r;
      if (beat.op == OP_ABSORB) begin
        take_byte(beat.data_byte);
        return;
      end
      len = nbits;
      take_byte(PAD_MARK);
      while (nbits[8:3] != LEN_POS) take_byte(8'h00);
      for (int i = 0; i < LEN_BYTES; i++) take_byte(len[63-8*i -: 8]);
      for (int i = 0; i < DIGEST_BYTES; i++) begin
        r.digest_byte = chain[i >> 2][31-8*(i & 3) -: 8];
        r.last_byte   = (i == DIGEST_BYTES - 1);
        digest_q.push_back(r);
      end
      chain = INIT_HASH;
      nbits = '0;
    endfunction

    // Compare one accepted digest beat with the oldest one owed
    function void check_digest_beat(sha1_out_t got);
      sha1_out_t want;
      if (digest_q.size() == 0) begin
        $display("%0t: digest beat with none pending: byte %h last %b",
                 $time, got.digest_byte, got.last_byte);
        mismatches++;
        return;
      end
      want = digest_q.pop_front();
      if (got.digest_byte !== want.digest_byte) begin
        $display("%0t: digest_byte expected %h actual %h",
                 $time, want.digest_byte, got.digest_byte);
        mismatches++;
      end
      if (got.last_byte !== want.last_byte) begin
        $display("%0t: last_byte expected %b actual %b",
                 $time, want.last_byte, got.last_byte);
        mismatches++;
      end
    endfunction

  endclass

endpackage

>>> tb/tb_sha1_hash_engine.sv
module tb_sha1_hash_engine;

  timeunit 1ns;
  timeprecision 1ps;

  import sha1_pkg::*;
  import sha1_digest_check_pkg::*;

  localparam int RAND_ITEMS  = 180;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 200;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int   cycle_cnt = 0;
  int   n_items   = 0;
  int   stall_left;
  logic long_hold;
  event hold_ev;

  digest_predictor sb = new();

  sha1_stream_if #(.payload_t(sha1_in_t))  msg_if ();
  sha1_stream_if #(.payload_t(sha1_out_t)) dig_if ();

  sha1_hash_engine u_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (dig_if)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat, hold it until taken, then maybe idle
  task automatic send_beat(input logic op, input logic [7:0] b);
    sha1_in_t beat;
    int gap;
    beat.op        = op;
    beat.data_byte = b;
    msg_if.valid   <= 1'b1;
    msg_if.payload <= beat;
    do @(posedge clk); while (!msg_if.ready);
    sb.accept_msg_beat(beat);
    n_items++;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_beat(OP_ABSORB, 8'($urandom_range(0, 255)));
    send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Stop offering and wait for every owed digest beat
  task automatic drain();
    msg_if.valid <= 1'b0;
    while (sb.digest_q.size() != 0) @(posedge clk);
  endtask

  // Lengths lean towards the padding and block boundaries
  function automatic int pick_len();
    int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 8);
    if (r < 85) return edges[$urandom_range(0, 9)];
    return $urandom_range(9, 130);
  endfunction

  // Take digest beats, check them, and stall at random
  always @(posedge clk) begin
    if (rst) begin
      dig_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (dig_if.valid && dig_if.ready) sb.check_digest_beat(dig_if.payload);
      if (long_hold) begin
        dig_if.ready <= 1'b0;
      end else if (calm) begin
        dig_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        dig_if.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = idle_len();
        dig_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Hold the digest side off for a long stretch when asked
  initial begin
    long_hold <= 1'b0;
    @(hold_ev);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int msgs;
    rst            <= 1'b1;
    calm           <= 1'b0;
    msg_if.valid   <= 1'b0;
    msg_if.payload <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, then short ones under a long digest hold
    send_beat(OP_FINISH, 8'h00);
    -> hold_ev;
    send_beat(OP_ABSORB, 8'h61);
    send_beat(OP_ABSORB, 8'h62);
    send_beat(OP_ABSORB, 8'h63);
    send_beat(OP_FINISH, 8'hff);
    send_beat(OP_ABSORB, 8'h00);
    send_beat(OP_FINISH, 8'h5a);
    send_beat(OP_ABSORB, 8'hff);
    send_beat(OP_ABSORB, 8'h80);
    send_beat(OP_FINISH, 8'ha5);
    send_beat(OP_ABSORB, 8'h01);
    send_beat(OP_ABSORB, 8'hfe);
    send_beat(OP_FINISH, 8'h00);
    // the state must have returned to initial values after each finish
    send_beat(OP_FINISH, 8'hff);
    drain();

    // Random messages of random content
    msgs    = 0;
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      calm <= ($urandom_range(0, 3) == 0);
      send_message(pick_len());
      msgs++;
      if (msgs == 2) drain();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
